### hw/rtl/rsv_pkg.sv
// ----------------------------------------------------------------------------
// rsv_pkg
// Shared types and constants of the RSA sign / verify modular power engine.
// ----------------------------------------------------------------------------
package rsv_pkg;

   // Width of operands, exponents and configuration registers
   localparam int WORD_WIDTH = 32;
   // Default modulus datapath width
   localparam int DEF_MOD_WIDTH = 32;
   // Step counter: covers the operand reduction and one serial multiply
   localparam int CNT_W = $clog2(WORD_WIDTH);

   // Configuration register indexes (byte address = 4 * index)
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_PRIV_EXP = 2'd0;
   localparam logic [1:0] REG_PUB_EXP = 2'd1;
   localparam logic [1:0] REG_MODULUS = 2'd2;

   // Reset key: primes 19 and 47, n = 893, e = 5, d = 497
   localparam logic [WORD_WIDTH-1:0] RST_PRIV_EXP = 32'd497;
   localparam logic [WORD_WIDTH-1:0] RST_PUB_EXP = 32'd5;
   localparam logic [WORD_WIDTH-1:0] RST_MODULUS = 32'd893;

   // Operation codes
   localparam logic FUNC_SIGN = 1'b0;
   localparam logic FUNC_VERIFY = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [WORD_WIDTH-1:0] message;
      logic [WORD_WIDTH-1:0] signature_in;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] power_value;
      logic                  signature_ok;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic zero_acc;
      logic red_step;
      logic mul_init;
      logic mul_step;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic mod_zero;
      logic expo_zero;
   } sts_type;

endpackage

### hw/rtl/rsv_dp.sv
// ----------------------------------------------------------------------------
// rsv_dp
// Datapath: operand reduction, two bit-serial modular multipliers sharing
// one multiplier word, exponent shifter and result registers.
// ----------------------------------------------------------------------------
module rsv_dp import rsv_pkg::*; #(
   parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
   input  logic                  clock,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  req_type               req,
   input  logic [WORD_WIDTH-1:0] priv_exp,
   input  logic [WORD_WIDTH-1:0] pub_exp,
   input  logic [WORD_WIDTH-1:0] modulus,
   output rsp_type               rsp
);

   localparam int W = MOD_WIDTH;

   logic [WORD_WIDTH-1:0] op_ff, op_in;
   logic [WORD_WIDTH-1:0] expo_ff, expo_in;
   logic [WORD_WIDTH-1:0] msg_ff, msg_in;
   logic                  func_ff, func_in;
   logic [W-1:0]          n_ff, n_in;
   logic [W-1:0]          base_ff, base_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [W-1:0]          mb_ff, mb_in;
   logic [W-1:0]          pa_ff, pa_in;
   logic [W-1:0]          pb_ff, pb_in;
   logic [W:0]            red_t;

   // 2p (+ a) mod n, with p < n and a <= n
   function automatic logic [W-1:0] dbl_add(input logic [W-1:0] p,
                                            input logic [W-1:0] a,
                                            input logic [W-1:0] n);
      logic [W:0] d;
      logic [W:0] s;
      begin
         d = {p, 1'b0};
         if (d >= {1'b0, n}) begin
            d = d - {1'b0, n};
         end
         s = {1'b0, d[W-1:0]} + {1'b0, a};
         if (s >= {1'b0, n}) begin
            s = s - {1'b0, n};
         end
         return s[W-1:0];
      end
   endfunction

   always_comb begin
      op_in   = op_ff;
      expo_in = expo_ff;
      msg_in  = msg_ff;
      func_in = func_ff;
      n_in    = n_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      mb_in   = mb_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;

      // shift one operand bit into the remainder
      red_t = {base_ff, op_ff[WORD_WIDTH-1]};
      if (red_t >= {1'b0, n_ff}) begin
         red_t = red_t - {1'b0, n_ff};
      end

      if (cmd.load) begin
         func_in = req.func;
         msg_in  = req.message;
         n_in    = modulus[W-1:0];
         base_in = '0;
         acc_in  = W'(1);
         if (req.func == FUNC_VERIFY) begin
            op_in   = req.signature_in;
            expo_in = pub_exp;
         end else begin
            op_in   = req.message;
            expo_in = priv_exp;
         end
      end
      if (cmd.zero_acc) begin
         acc_in = '0;
      end
      if (cmd.red_step) begin
         base_in = red_t[W-1:0];
         op_in   = {op_ff[WORD_WIDTH-2:0], 1'b0};
      end
      if (cmd.mul_init) begin
         pa_in = '0;
         pb_in = '0;
         mb_in = base_ff;
      end
      if (cmd.mul_step) begin
         // MSB first: p = 2p + bit * a mod n
         pa_in = dbl_add(pa_ff, mb_ff[W-1] ? acc_ff : '0, n_ff);
         pb_in = dbl_add(pb_ff, mb_ff[W-1] ? base_ff : '0, n_ff);
         mb_in = {mb_ff[W-2:0], 1'b0};
      end
      if (cmd.commit) begin
         if (expo_ff[0]) begin
            acc_in = pa_ff;
         end
         base_in = pb_ff;
         expo_in = {1'b0, expo_ff[WORD_WIDTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      expo_ff <= expo_in;
      msg_ff  <= msg_in;
      func_ff <= func_in;
      n_ff    <= n_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      mb_ff   <= mb_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
   end

   assign sts.mod_zero  = (n_ff == '0);
   assign sts.expo_zero = (expo_ff == '0);

   assign rsp.power_value  = WORD_WIDTH'(acc_ff);
   assign rsp.signature_ok = (func_ff == FUNC_VERIFY) && (WORD_WIDTH'(acc_ff) == msg_ff);

endmodule

### hw/rtl/rsv_ctrl.sv
// ----------------------------------------------------------------------------
// rsv_ctrl
// Controller: sequences load, operand reduction, one serial multiply pass
// per exponent bit, and the result strobe.
// ----------------------------------------------------------------------------
module rsv_ctrl import rsv_pkg::*; #(
   parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    done,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_REDUCE = 3'd2;
   localparam logic [2:0] S_LOOP   = 3'd3;
   localparam logic [2:0] S_MUL    = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(WORD_WIDTH - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MOD_WIDTH - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            if (sts.mod_zero) begin
               cmd.zero_acc = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == RED_LAST) begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            cnt_in = '0;
            if (sts.expo_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.mul_init = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_LOOP;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

`ifndef SYNTHESIS
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("result strobe longer than one cycle");

   a_start_load: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_CHECK))
      else $error("accepted word did not start an operation");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (cnt_ff <= MUL_LAST))
      else $error("multiply step count overrun");

   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(done) |-> (($past(state_ff) == S_LOOP) && $past(sts.expo_zero))
                   || (($past(state_ff) == S_CHECK) && $past(sts.mod_zero)))
      else $error("result strobe without finished exponent or zero modulus");
`endif

endmodule

### hw/rtl/rsa_sign_verify_modexp_top.sv
// ----------------------------------------------------------------------------
// rsa_sign_verify_modexp_top
// RSA sign / verify by right-to-left square-and-multiply modular power.
// ----------------------------------------------------------------------------
// One operation at a time: a word is taken when start is high and busy is
// low, and its result appears on rsp_data for exactly one cycle with
// rsp_valid high; the receiver must take it then. An operation reduces the
// operand, then makes one multiply pass for each exponent bit up to and
// including the highest set bit (none for a zero exponent). The passes run
// on the two bit-serial modular multipliers, which take one multiplier bit
// per cycle and run the multiply and the square of each exponent bit side
// by side. A zero modulus skips all work and returns 0.
// Write the key registers only while busy is low.
// ----------------------------------------------------------------------------
module rsa_sign_verify_modexp_top import rsv_pkg::*; #(
   parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [WORD_WIDTH-1:0] pwdata,
   output logic [WORD_WIDTH-1:0] prdata,
   output logic                  pready
);

   logic [WORD_WIDTH-1:0] priv_exp_ff, priv_exp_in;
   logic [WORD_WIDTH-1:0] pub_exp_ff, pub_exp_in;
   logic [WORD_WIDTH-1:0] modulus_ff, modulus_in;
   logic                  csr_wr;
   cmd_type               cmd;
   sts_type               sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      priv_exp_in = priv_exp_ff;
      pub_exp_in  = pub_exp_ff;
      modulus_in  = modulus_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            REG_PRIV_EXP: priv_exp_in = pwdata;
            REG_PUB_EXP:  pub_exp_in  = pwdata;
            REG_MODULUS:  modulus_in  = pwdata;
            default: begin
               // drop writes outside the register map
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_PRIV_EXP: prdata = priv_exp_ff;
         REG_PUB_EXP:  prdata = pub_exp_ff;
         REG_MODULUS:  prdata = modulus_ff;
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priv_exp_ff <= RST_PRIV_EXP;
         pub_exp_ff  <= RST_PUB_EXP;
         modulus_ff  <= RST_MODULUS;
      end else begin
         priv_exp_ff <= priv_exp_in;
         pub_exp_ff  <= pub_exp_in;
         modulus_ff  <= modulus_in;
      end
   end

   rsv_ctrl #(
      .MOD_WIDTH(MOD_WIDTH)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .done (rsp_valid),
      .cmd  (cmd),
      .sts  (sts)
   );

   rsv_dp #(
      .MOD_WIDTH(MOD_WIDTH)
   ) u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .sts     (sts),
      .req     (req_data),
      .priv_exp(priv_exp_ff),
      .pub_exp (pub_exp_ff),
      .modulus (modulus_ff),
      .rsp     (rsp_data)
   );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RSA sign / verify modular power engine.
// Starts with a short table of directed words and key writes, then random
// phases, each with a new key written over the register port. Every accepted
// word is scored against a typed value or a local square-and-multiply model.
// ----------------------------------------------------------------------------
module tb_top;
   import rsv_pkg::*;

   localparam int MOD_W = DEF_MOD_WIDTH;
   localparam int OP_CYCLES_MAX = 3 + WORD_WIDTH + WORD_WIDTH * (MOD_W + 2) + 1;
   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 44;
   localparam int CYCLE_LIMIT = 3 * (PHASES * WORDS_PER_PHASE + 40) * (OP_CYCLES_MAX + 64);
   localparam logic [63:0] MOD_MASK = (64'd1 << MOD_W) - 64'd1;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [1:0]            reg_idx;
      logic                  func;
      logic [WORD_WIDTH-1:0] arg_a;    // message, or register value
      logic [WORD_WIDTH-1:0] arg_b;    // signature_in
      logic                  typed;
      logic [WORD_WIDTH-1:0] pv;
      logic                  ok;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [WORD_WIDTH-1:0] pwdata = '0;
   logic [WORD_WIDTH-1:0] prdata;
   logic                  pready;

   // Hand-typed expectation that travels with the word on req_data
   logic                  row_typed = 1'b0;
   rsp_type               row_rsp = '0;

   // Local copy of the key registers
   logic [WORD_WIDTH-1:0] key_priv = RST_PRIV_EXP;
   logic [WORD_WIDTH-1:0] key_pub = RST_PUB_EXP;
   logic [WORD_WIDTH-1:0] key_mod = RST_MODULUS;

   rsp_type               expected_powers[$];
   stim_row_type          stim_table[$];
   rsp_type               want;
   int                    error_count = 0;
   int                    csr_error_count = 0;
   int                    sign_count = 0;
   int                    verify_count = 0;
   int                    match_count = 0;
   int                    csr_writes = 0;
   int                    cycle_count = 0;
   int                    idle_pct = 15;

   rsa_sign_verify_modexp_top #(
      .MOD_WIDTH(MOD_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Right-to-left square and multiply, 64-bit products
   function automatic logic [WORD_WIDTH-1:0] mod_pow(input logic [WORD_WIDTH-1:0] base,
                                                     input logic [WORD_WIDTH-1:0] expo,
                                                     input logic [WORD_WIDTH-1:0] modulus);
      logic [63:0] n;
      logic [63:0] acc;
      logic [63:0] b;
      logic [63:0] e;
      int          i;
      n = {32'd0, modulus} & MOD_MASK;
      if (n == 64'd0) begin
         return '0;
      end
      acc = 64'd1;
      b = {32'd0, base} % n;
      e = {32'd0, expo};
      for (i = 0; i < WORD_WIDTH && e != 64'd0; i++) begin
         if (e[0]) begin
            acc = (acc * b) % n;
         end
         b = (b * b) % n;
         e = e >> 1;
      end
      return acc[WORD_WIDTH-1:0];
   endfunction

   function automatic rsp_type predict_power(input req_type w);
      rsp_type r;
      if (w.func == FUNC_SIGN) begin
         r.power_value = mod_pow(w.message, key_priv, key_mod);
         r.signature_ok = 1'b0;
      end else begin
         r.power_value = mod_pow(w.signature_in, key_pub, key_mod);
         r.signature_ok = (r.power_value == w.message);
      end
      return r;
   endfunction

   // Score results and record accepted words
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rsa_sign_verify_modexp_top verification failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (expected_powers.size() == 0) begin
               $error("result word with nothing expected: power_value %h signature_ok %b",
                      rsp_data.power_value, rsp_data.signature_ok);
               error_count++;
            end else begin
               want = expected_powers.pop_front();
               if (rsp_data.power_value !== want.power_value) begin
                  $error("power_value expected %h actual %h",
                         want.power_value, rsp_data.power_value);
                  error_count++;
               end
               if (rsp_data.signature_ok !== want.signature_ok) begin
                  $error("signature_ok expected %b actual %b",
                         want.signature_ok, rsp_data.signature_ok);
                  error_count++;
               end
               if (rsp_data.signature_ok === 1'b1) begin
                  match_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_powers.push_back(row_typed ? row_rsp : predict_power(req_data));
            if (req_data.func == FUNC_SIGN) begin
               sign_count++;
            end else begin
               verify_count++;
            end
         end
      end
   end

   task automatic send_word(input req_type w, input logic typed, input rsp_type typed_rsp);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      row_typed <= typed;
      row_rsp <= typed_rsp;
      // hold the word until an edge with busy low takes it
      do @(posedge clock); while (busy);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [WORD_WIDTH-1:0] value);
      start <= 1'b0;
      // wait for a word taken at this edge to show on busy, then for it to finish
      do @(posedge clock); while (expected_powers.size() != 0 || busy);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_PRIV_EXP: key_priv = value;
         REG_PUB_EXP:  key_pub = value;
         REG_MODULUS:  key_mod = value;
         default: ;
      endcase
      csr_writes++;
      // read the register back
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         $error("prdata expected %h actual %h", value, prdata);
         csr_error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic tab(input row_kind_type kind, input logic [1:0] idx, input logic func,
                      input logic [WORD_WIDTH-1:0] a, input logic [WORD_WIDTH-1:0] b,
                      input logic typed, input logic [WORD_WIDTH-1:0] pv, input logic ok);
      stim_row_type r;
      r.kind = kind;
      r.reg_idx = idx;
      r.func = func;
      r.arg_a = a;
      r.arg_b = b;
      r.typed = typed;
      r.pv = pv;
      r.ok = ok;
      stim_table.push_back(r);
   endtask

   task automatic random_word(input logic real_key);
      req_type                w;
      logic [WORD_WIDTH-1:0]  pv;
      int                     pick;
      int                     variant;
      pick = $urandom_range(99);
      w.signature_in = $urandom;
      w.message = $urandom;
      if (pick < 40) begin
         w.func = FUNC_SIGN;
         if ($urandom_range(1) == 1 && key_mod != 0) begin
            w.message = $urandom % key_mod;
         end
      end else if (pick < 80) begin
         // verify: the message is the value the signature recovers, or a near miss
         w.func = FUNC_VERIFY;
         if (real_key && key_mod != 0) begin
            w.message = $urandom % key_mod;
            w.signature_in = mod_pow(w.message, key_priv, key_mod);
         end else begin
            pv = mod_pow(w.signature_in, key_pub, key_mod);
            variant = $urandom_range(99);
            if (variant < 70) begin
               w.message = pv;
            end else if (variant < 85) begin
               w.message = pv + key_mod;   // same residue, must still mismatch
            end else begin
               w.message = pv ^ (32'd1 << $urandom_range(WORD_WIDTH - 1));
            end
         end
      end else begin
         w.func = FUNC_VERIFY;
      end
      send_word(w, 1'b0, '0);
   endtask

   initial begin
      req_type      w;
      rsp_type      t;
      stim_row_type r;
      int           p;
      int           k;
      logic         real_key;

      // reset key: n = 893, e = 5, d = 497
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd0, 32'hFFFF_FFFF, 1, 32'd0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd1, 32'd0, 1, 32'd1, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd1, 32'd1, 1, 32'd1, 1);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd0, 32'd0, 1, 32'd0, 1);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd893, 32'd0, 1, 32'd0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd892, 32'd892, 1, 32'd892, 1);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd892, 32'd0, 1, 32'd892, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'hFFFF_FFFF, 32'd0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd2, 32'h5A5A_A5A5, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd0, 32'h1234_5678, 0, 0, 0);
      // zero exponents give 1 with no reduction
      tab(ROW_CFG, REG_PRIV_EXP, 0, 32'd0, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd12345, 32'd0, 1, 32'd1, 0);
      tab(ROW_CFG, REG_PUB_EXP, 0, 32'd0, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd1, 32'd7, 1, 32'd1, 1);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd0, 32'd0, 1, 32'd1, 0);
      // modulus of one
      tab(ROW_CFG, REG_MODULUS, 0, 32'd1, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd5, 32'd0, 1, 32'd1, 0);
      tab(ROW_CFG, REG_PRIV_EXP, 0, 32'd3, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd5, 32'd0, 1, 32'd0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd1, 32'd9, 1, 32'd1, 1);
      // modulus of zero returns 0
      tab(ROW_CFG, REG_MODULUS, 0, 32'd0, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd5, 32'd0, 1, 32'd0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd0, 32'd5, 1, 32'd0, 1);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd3, 32'd5, 1, 32'd0, 0);
      // all-ones key
      tab(ROW_CFG, REG_MODULUS, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      tab(ROW_CFG, REG_PRIV_EXP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      tab(ROW_CFG, REG_PUB_EXP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'hFFFF_FFFE, 32'd0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd0, 32'hFFFF_FFFE, 0, 0, 0);
      // smallest legal modulus
      tab(ROW_CFG, REG_MODULUS, 0, 32'd2, 0, 0, 0, 0);
      tab(ROW_ITEM, 0, FUNC_SIGN,   32'd3, 32'd0, 1, 32'd1, 0);
      tab(ROW_ITEM, 0, FUNC_VERIFY, 32'd0, 32'd2, 1, 32'd0, 1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         r = stim_table[i];
         if (r.kind == ROW_CFG) begin
            csr_write(r.reg_idx, r.arg_a);
         end else begin
            w.func = r.func;
            w.message = r.arg_a;
            w.signature_in = r.arg_b;
            t.power_value = r.pv;
            t.signature_ok = r.ok;
            send_word(w, r.typed, t);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         real_key = 1'b0;
         idle_pct = 15;
         case (p)
            0: begin
               csr_write(REG_PRIV_EXP, RST_PRIV_EXP);
               csr_write(REG_PUB_EXP, RST_PUB_EXP);
               csr_write(REG_MODULUS, RST_MODULUS);
               real_key = 1'b1;
            end
            1: begin
               // primes 61 and 53
               csr_write(REG_PRIV_EXP, 32'd2753);
               csr_write(REG_PUB_EXP, 32'd17);
               csr_write(REG_MODULUS, 32'd3233);
               real_key = 1'b1;
            end
            2: begin
               csr_write(REG_PRIV_EXP, $urandom);
               csr_write(REG_PUB_EXP, $urandom);
               csr_write(REG_MODULUS, $urandom | 32'h8000_0000);
               idle_pct = 0;   // back-to-back stretch
            end
            3: begin
               csr_write(REG_PRIV_EXP, $urandom);
               csr_write(REG_PUB_EXP, $urandom);
               csr_write(REG_MODULUS, $urandom_range(255, 2));
            end
            4: begin
               csr_write(REG_PRIV_EXP, $urandom & 32'h0000_FFFF);
               csr_write(REG_PUB_EXP, ($urandom_range(1) == 1) ? 32'd3 : 32'd65537);
               csr_write(REG_MODULUS, $urandom | 32'd2);
            end
            default: begin
               csr_write(REG_PRIV_EXP, 32'hFFFF_FFFF);
               csr_write(REG_PUB_EXP, 32'd1);
               csr_write(REG_MODULUS, $urandom_range(65535, 2));
            end
         endcase
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            random_word(real_key);
         end
      end

      start <= 1'b0;
      // let the last word show on busy, then drain its result
      do @(posedge clock); while (expected_powers.size() != 0 || busy);
      repeat (20) @(posedge clock);

      $display("Covered %0d sign and %0d verify words (%0d matched) over %0d key writes.",
               sign_count, verify_count, match_count, csr_writes);
      $display("Keys ranged from the reset pair through zero, one and all-ones moduli.");
      if (error_count == 0 && csr_error_count == 0) begin
         $display("rsa_sign_verify_modexp_top verification clean");
      end else begin
         $display("rsa_sign_verify_modexp_top verification failed");
      end
      $finish;
   end

endmodule
